>>> hw/rtl/ecsm_pkg.sv
// Shared types, constants and the microprogram of the scalar multiplier.
package ecsm_pkg;

	localparam int FIELD_BITS_DEF  = 31;
	localparam int SCALAR_BITS_DEF = 64;
	localparam int REG_DEPTH       = 16;
	localparam int RADDR_W         = 4;
	localparam int UPC_W           = 6;
	localparam int ECNT_W          = 5;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A = 2'd1;

	// Register file slots. The last four are aliases resolved by the controller
	// to the accumulator or to the running point, depending on the mode.
	localparam logic [RADDR_W-1:0] R_QX   = 4'd0;
	localparam logic [RADDR_W-1:0] R_QY   = 4'd1;
	localparam logic [RADDR_W-1:0] R_AX   = 4'd2;
	localparam logic [RADDR_W-1:0] R_AY   = 4'd3;
	localparam logic [RADDR_W-1:0] R_A    = 4'd4;
	localparam logic [RADDR_W-1:0] R_T1   = 4'd5;
	localparam logic [RADDR_W-1:0] R_T2   = 4'd6;
	localparam logic [RADDR_W-1:0] R_T3   = 4'd7;
	localparam logic [RADDR_W-1:0] R_B    = 4'd8;
	localparam logic [RADDR_W-1:0] R_V    = 4'd9;
	localparam logic [RADDR_W-1:0] R_ZERO = 4'd10;
	localparam logic [RADDR_W-1:0] R_ONE  = 4'd11;
	localparam logic [RADDR_W-1:0] R_SX   = 4'd12;
	localparam logic [RADDR_W-1:0] R_SY   = 4'd13;
	localparam logic [RADDR_W-1:0] R_DX   = 4'd14;
	localparam logic [RADDR_W-1:0] R_DY   = 4'd15;

	// Source selectors carried in the ra field of reduce and constant ops.
	localparam logic [RADDR_W-1:0] SRC_PX   = 4'd0;
	localparam logic [RADDR_W-1:0] SRC_PY   = 4'd1;
	localparam logic [RADDR_W-1:0] SRC_CA   = 4'd2;
	localparam logic [RADDR_W-1:0] VAL_ZERO = 4'd0;
	localparam logic [RADDR_W-1:0] VAL_ONE  = 4'd1;

	localparam logic [UPC_W-1:0] UPC_LOOP     = 6'd7;
	localparam logic [UPC_W-1:0] UPC_AFTERADD = 6'd10;
	localparam logic [UPC_W-1:0] UPC_PADD     = 6'd14;
	localparam logic [UPC_W-1:0] UPC_CHORD    = 6'd28;
	localparam logic [UPC_W-1:0] UPC_INV      = 6'd30;
	localparam logic [UPC_W-1:0] UPC_ELOOP    = 6'd33;
	localparam logic [UPC_W-1:0] UPC_ESQ      = 6'd35;
	localparam logic [UPC_W-1:0] UPC_COPY     = 6'd47;
	localparam logic [UPC_W-1:0] UPC_MKINF    = 6'd50;
	localparam logic [UPC_W-1:0] UPC_RETN     = 6'd51;
	localparam logic [UPC_W-1:0] UPC_FIN      = 6'd52;

	typedef enum logic [3:0] {
		OP_CONST, OP_RED, OP_ADD, OP_SUB, OP_MUL, OP_CMP, OP_FIN, OP_JMP,
		OP_MODEADD, OP_MODEDBL, OP_SHIFT, OP_EINIT, OP_EJMP, OP_RET, OP_RETINF, OP_RETN
	} uop_t;

	typedef enum logic [3:0] {
		C_ALWAYS, C_NOTNEG, C_NOTBIT0, C_MAGZERO, C_QINF, C_ADDINF, C_NOTEQ, C_ZERO,
		C_NOTEBIT
	} cond_t;

	typedef struct packed {
		uop_t               op;
		cond_t              cond;
		logic [RADDR_W-1:0] rd;
		logic [RADDR_W-1:0] ra;
		logic [RADDR_W-1:0] rb;
		logic [UPC_W-1:0]   tgt;
	} uinstr_t;

	typedef struct packed {
		logic               load;
		logic               rd;
		logic               ex;
		uop_t               op;
		logic [RADDR_W-1:0] raddr_a;
		logic [RADDR_W-1:0] raddr_b;
		logic [RADDR_W-1:0] waddr;
		logic [RADDR_W-1:0] sel;
		logic [ECNT_W-1:0]  ecnt;
		logic               inf;
	} dp_cmd_t;

	typedef struct packed {
		logic eq;
		logic zero;
		logic ebit;
		logic mul_done;
		logic p_small;
	} dp_stat_t;

	function automatic uinstr_t mk(uop_t op, cond_t c, logic [RADDR_W-1:0] rd,
			logic [RADDR_W-1:0] ra, logic [RADDR_W-1:0] rb, logic [UPC_W-1:0] tgt);
		uinstr_t u;
		u.op   = op;
		u.cond = c;
		u.rd   = rd;
		u.ra   = ra;
		u.rb   = rb;
		u.tgt  = tgt;
		return u;
	endfunction

	function automatic uinstr_t uprog(logic [UPC_W-1:0] a);
		uinstr_t u;
		unique case (a)
			6'd0:  u = mk(OP_CONST,   C_ALWAYS,  R_ZERO, VAL_ZERO, R_ZERO, '0);
			6'd1:  u = mk(OP_CONST,   C_ALWAYS,  R_ONE,  VAL_ONE,  R_ZERO, '0);
			6'd2:  u = mk(OP_RED,     C_ALWAYS,  R_QX,   SRC_PX,   R_ZERO, '0);
			6'd3:  u = mk(OP_RED,     C_ALWAYS,  R_QY,   SRC_PY,   R_ZERO, '0);
			6'd4:  u = mk(OP_RED,     C_ALWAYS,  R_A,    SRC_CA,   R_ZERO, '0);
			6'd5:  u = mk(OP_JMP,     C_NOTNEG,  R_ZERO, R_ZERO,   R_ZERO, UPC_LOOP);
			6'd6:  u = mk(OP_SUB,     C_ALWAYS,  R_QY,   R_ZERO,   R_QY,   '0);
			6'd7:  u = mk(OP_JMP,     C_NOTBIT0, R_ZERO, R_ZERO,   R_ZERO, UPC_AFTERADD);
			6'd8:  u = mk(OP_MODEADD, C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, '0);
			6'd9:  u = mk(OP_JMP,     C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, UPC_PADD);
			6'd10: u = mk(OP_SHIFT,   C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, '0);
			6'd11: u = mk(OP_JMP,     C_MAGZERO, R_ZERO, R_ZERO,   R_ZERO, UPC_FIN);
			6'd12: u = mk(OP_MODEDBL, C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, '0);
			6'd13: u = mk(OP_JMP,     C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, UPC_PADD);
			6'd14: u = mk(OP_JMP,     C_QINF,    R_ZERO, R_ZERO,   R_ZERO, UPC_RETN);
			6'd15: u = mk(OP_JMP,     C_ADDINF,  R_ZERO, R_ZERO,   R_ZERO, UPC_COPY);
			6'd16: u = mk(OP_CMP,     C_ALWAYS,  R_ZERO, R_SX,     R_QX,   '0);
			6'd17: u = mk(OP_JMP,     C_NOTEQ,   R_ZERO, R_ZERO,   R_ZERO, UPC_CHORD);
			6'd18: u = mk(OP_ADD,     C_ALWAYS,  R_T1,   R_SY,     R_QY,   '0);
			6'd19: u = mk(OP_JMP,     C_ZERO,    R_ZERO, R_ZERO,   R_ZERO, UPC_MKINF);
			6'd20: u = mk(OP_CMP,     C_ALWAYS,  R_ZERO, R_SY,     R_QY,   '0);
			6'd21: u = mk(OP_JMP,     C_NOTEQ,   R_ZERO, R_ZERO,   R_ZERO, UPC_CHORD);
			6'd22: u = mk(OP_MUL,     C_ALWAYS,  R_T1,   R_SX,     R_SX,   '0);
			6'd23: u = mk(OP_ADD,     C_ALWAYS,  R_T2,   R_T1,     R_T1,   '0);
			6'd24: u = mk(OP_ADD,     C_ALWAYS,  R_T1,   R_T2,     R_T1,   '0);
			6'd25: u = mk(OP_ADD,     C_ALWAYS,  R_T1,   R_T1,     R_A,    '0);
			6'd26: u = mk(OP_ADD,     C_ALWAYS,  R_T2,   R_SY,     R_SY,   '0);
			6'd27: u = mk(OP_JMP,     C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, UPC_INV);
			6'd28: u = mk(OP_SUB,     C_ALWAYS,  R_T1,   R_QY,     R_SY,   '0);
			6'd29: u = mk(OP_SUB,     C_ALWAYS,  R_T2,   R_QX,     R_SX,   '0);
			6'd30: u = mk(OP_ADD,     C_ALWAYS,  R_B,    R_T2,     R_ZERO, '0);
			6'd31: u = mk(OP_ADD,     C_ALWAYS,  R_V,    R_ONE,    R_ZERO, '0);
			6'd32: u = mk(OP_EINIT,   C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, '0);
			6'd33: u = mk(OP_JMP,     C_NOTEBIT, R_ZERO, R_ZERO,   R_ZERO, UPC_ESQ);
			6'd34: u = mk(OP_MUL,     C_ALWAYS,  R_V,    R_V,      R_B,    '0);
			6'd35: u = mk(OP_MUL,     C_ALWAYS,  R_B,    R_B,      R_B,    '0);
			6'd36: u = mk(OP_EJMP,    C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, UPC_ELOOP);
			6'd37: u = mk(OP_MUL,     C_ALWAYS,  R_B,    R_T1,     R_V,    '0);
			6'd38: u = mk(OP_MUL,     C_ALWAYS,  R_T1,   R_B,      R_B,    '0);
			6'd39: u = mk(OP_SUB,     C_ALWAYS,  R_T1,   R_T1,     R_SX,   '0);
			6'd40: u = mk(OP_SUB,     C_ALWAYS,  R_T3,   R_T1,     R_QX,   '0);
			6'd41: u = mk(OP_SUB,     C_ALWAYS,  R_T2,   R_SX,     R_T3,   '0);
			6'd42: u = mk(OP_MUL,     C_ALWAYS,  R_T2,   R_B,      R_T2,   '0);
			6'd43: u = mk(OP_SUB,     C_ALWAYS,  R_T2,   R_T2,     R_SY,   '0);
			6'd44: u = mk(OP_ADD,     C_ALWAYS,  R_DX,   R_T3,     R_ZERO, '0);
			6'd45: u = mk(OP_ADD,     C_ALWAYS,  R_DY,   R_T2,     R_ZERO, '0);
			6'd46: u = mk(OP_RET,     C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, '0);
			6'd47: u = mk(OP_ADD,     C_ALWAYS,  R_DX,   R_QX,     R_ZERO, '0);
			6'd48: u = mk(OP_ADD,     C_ALWAYS,  R_DY,   R_QY,     R_ZERO, '0);
			6'd49: u = mk(OP_RET,     C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, '0);
			6'd50: u = mk(OP_RETINF,  C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, '0);
			6'd51: u = mk(OP_RETN,    C_ALWAYS,  R_ZERO, R_ZERO,   R_ZERO, '0);
			default: u = mk(OP_FIN,   C_ALWAYS,  R_ZERO, R_AX,     R_AY,   '0);
		endcase
		return u;
	endfunction

endpackage

>>> hw/rtl/ecsm_ram.sv
// Generic register file RAM: one write port, two registered read ports.
module ecsm_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule

>>> hw/rtl/ecsm_modmul.sv
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
module ecsm_modmul #(
	parameter int FIELD_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [FIELD_BITS-1:0] a,
	input  logic [FIELD_BITS-1:0] b,
	input  logic [FIELD_BITS-1:0] p,
	output logic                  done,
	output logic [FIELD_BITS-1:0] prod
);
	localparam int CW = $clog2(FIELD_BITS);
	localparam logic [CW-1:0] LAST = CW'(FIELD_BITS - 1);

	logic                  run_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [FIELD_BITS-1:0] a_q;
	logic [FIELD_BITS-1:0] b_q;
	logic [FIELD_BITS-1:0] acc_q;
	logic [FIELD_BITS+1:0] t0;
	logic [FIELD_BITS+1:0] t1;
	logic [FIELD_BITS+1:0] t2;
	logic [FIELD_BITS+1:0] pw;

	// The accumulator stays below p, so 2*acc + a is below 3p: two trial
	// subtractions bring it back into range.
	always_comb begin
		pw = {2'b00, p};
		t0 = {1'b0, acc_q, 1'b0} + (b_q[FIELD_BITS-1] ? {2'b00, a_q} : '0);
		t1 = (t0 >= pw) ? t0 - pw : t0;
		t2 = (t1 >= pw) ? t1 - pw : t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			b_q   <= {b_q[FIELD_BITS-2:0], 1'b0};
			acc_q <= t2[FIELD_BITS-1:0];
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

>>> hw/rtl/ecsm_datapath.sv
// Datapath: configuration registers, field register file, modular ALU and multiplier.
module ecsm_datapath #(
	parameter int FIELD_BITS = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ecsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [FIELD_BITS-1:0]           cfg_data,
	input  logic [FIELD_BITS-1:0]           px,
	input  logic [FIELD_BITS-1:0]           py,
	input  ecsm_pkg::dp_cmd_t               cmd,
	output ecsm_pkg::dp_stat_t              stat,
	output logic                            done,
	output logic [FIELD_BITS-1:0]           rx,
	output logic [FIELD_BITS-1:0]           ry,
	output logic                            result_infinity
);
	import ecsm_pkg::*;

	localparam int EIW = $clog2(FIELD_BITS);

	logic [FIELD_BITS-1:0] modulus_q;
	logic [FIELD_BITS-1:0] coeff_a_q;
	logic [FIELD_BITS-1:0] px_q;
	logic [FIELD_BITS-1:0] py_q;
	logic [FIELD_BITS-1:0] rdata_a;
	logic [FIELD_BITS-1:0] rdata_b;
	logic [FIELD_BITS-1:0] wdata;
	logic                  we;
	logic                  eq_q;
	logic                  zero_q;
	logic                  done_q;
	logic                  rinf_q;
	logic [FIELD_BITS-1:0] rx_q;
	logic [FIELD_BITS-1:0] ry_q;
	logic [FIELD_BITS:0]   sum;
	logic [FIELD_BITS:0]   sum_r;
	logic [FIELD_BITS:0]   dif;
	logic [FIELD_BITS:0]   dif_r;
	logic [FIELD_BITS-1:0] pm2;
	logic                  mul_start;
	logic [FIELD_BITS-1:0] mul_a;
	logic [FIELD_BITS-1:0] mul_b;
	logic                  mul_done;
	logic [FIELD_BITS-1:0] mul_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= '1;
			coeff_a_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MODULUS) begin
				modulus_q <= cfg_data;
			end else if (cfg_index == CFG_COEFF_A) begin
				coeff_a_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= px;
			py_q <= py;
		end
	end

	always_comb begin
		sum   = {1'b0, rdata_a} + {1'b0, rdata_b};
		sum_r = (sum >= {1'b0, modulus_q}) ? sum - {1'b0, modulus_q} : sum;
		dif   = {1'b0, rdata_a} - {1'b0, rdata_b};
		dif_r = (rdata_a < rdata_b) ? dif + {1'b0, modulus_q} : dif;
		pm2   = modulus_q - FIELD_BITS'(2);
	end

	// Reduction of raw inputs runs through the multiplier as 1 * value.
	always_comb begin
		mul_start = cmd.ex && (cmd.op == OP_MUL || cmd.op == OP_RED);
		mul_a     = rdata_a;
		mul_b     = rdata_b;
		if (cmd.op == OP_RED) begin
			mul_a = FIELD_BITS'(1);
			unique case (cmd.sel)
				SRC_PX:  mul_b = px_q;
				SRC_PY:  mul_b = py_q;
				default: mul_b = coeff_a_q;
			endcase
		end
	end

	always_comb begin
		we    = 1'b0;
		wdata = mul_p;
		if (mul_done) begin
			we = 1'b1;
		end else if (cmd.ex) begin
			unique case (cmd.op)
				OP_ADD: begin
					we    = 1'b1;
					wdata = sum_r[FIELD_BITS-1:0];
				end
				OP_SUB: begin
					we    = 1'b1;
					wdata = dif_r[FIELD_BITS-1:0];
				end
				OP_CONST: begin
					we    = 1'b1;
					wdata = (cmd.sel == VAL_ONE) ? FIELD_BITS'(1) : '0;
				end
				default: we = 1'b0;
			endcase
		end
	end

	ecsm_ram #(
		.WIDTH(FIELD_BITS),
		.DEPTH(REG_DEPTH)
	) u_regs (
		.clk    (clk),
		.we     (we),
		.waddr  (cmd.waddr),
		.wdata  (wdata),
		.re     (cmd.rd),
		.raddr_a(cmd.raddr_a),
		.raddr_b(cmd.raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	ecsm_modmul #(
		.FIELD_BITS(FIELD_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.p     (modulus_q),
		.done  (mul_done),
		.prod  (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_q   <= 1'b0;
			zero_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.ex && cmd.op == OP_FIN;
			if (cmd.ex && cmd.op == OP_CMP) begin
				eq_q <= rdata_a == rdata_b;
			end
			if (cmd.ex && cmd.op == OP_ADD) begin
				zero_q <= sum_r == '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ex && cmd.op == OP_FIN) begin
			rinf_q <= cmd.inf;
			rx_q   <= cmd.inf ? '0 : rdata_a;
			ry_q   <= cmd.inf ? '0 : rdata_b;
		end
	end

	assign stat.eq       = eq_q;
	assign stat.zero     = zero_q;
	assign stat.ebit     = pm2[cmd.ecnt[EIW-1:0]];
	assign stat.mul_done = mul_done;
	assign stat.p_small  = modulus_q < FIELD_BITS'(3);

	assign done            = done_q;
	assign rx              = rx_q;
	assign ry              = ry_q;
	assign result_infinity = rinf_q;
endmodule

>>> hw/rtl/ecsm_ctrl.sv
// Controller: microprogram sequencer, scalar bits and point-at-infinity flags.
module ecsm_ctrl #(
	parameter int FIELD_BITS  = 31,
	parameter int SCALAR_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SCALAR_BITS-1:0] scalar,
	input  logic                   point_infinity,
	input  ecsm_pkg::dp_stat_t     stat,
	output ecsm_pkg::dp_cmd_t      cmd,
	output logic                   busy
);
	import ecsm_pkg::*;

	localparam logic [ECNT_W-1:0] ELAST = ECNT_W'(FIELD_BITS - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_MULW  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [UPC_W-1:0]       upc_q;
	logic [SCALAR_BITS-1:0] mag_q;
	logic                   neg_q;
	logic                   dbl_q;
	logic                   acc_inf_q;
	logic                   q_inf_q;
	logic [ECNT_W-1:0]      ecnt_q;
	uinstr_t                u;
	logic                   cond_ok;
	logic [SCALAR_BITS-1:0] start_mag;
	logic                   start_neg;

	function automatic logic [RADDR_W-1:0] resolve(logic [RADDR_W-1:0] r, logic dbl);
		logic [RADDR_W-1:0] o;
		o = r;
		if (r == R_SX || r == R_DX) begin
			o = dbl ? R_QX : R_AX;
		end else if (r == R_SY || r == R_DY) begin
			o = dbl ? R_QY : R_AY;
		end
		return o;
	endfunction

	assign u         = uprog(upc_q);
	assign start_neg = scalar[SCALAR_BITS-1];
	assign start_mag = start_neg ? (~scalar + 1'b1) : scalar;

	always_comb begin
		unique case (u.cond)
			C_ALWAYS:  cond_ok = 1'b1;
			C_NOTNEG:  cond_ok = !neg_q;
			C_NOTBIT0: cond_ok = !mag_q[0];
			C_MAGZERO: cond_ok = mag_q == '0;
			C_QINF:    cond_ok = q_inf_q;
			C_ADDINF:  cond_ok = !dbl_q && acc_inf_q;
			C_NOTEQ:   cond_ok = !stat.eq;
			C_ZERO:    cond_ok = stat.zero;
			C_NOTEBIT: cond_ok = !stat.ebit;
			default:   cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		cmd.load    = start && state_q == ST_IDLE;
		cmd.rd      = 1'b0;
		cmd.ex      = state_q == ST_EXEC;
		cmd.op      = u.op;
		cmd.raddr_a = resolve(u.ra, dbl_q);
		cmd.raddr_b = resolve(u.rb, dbl_q);
		cmd.waddr   = resolve(u.rd, dbl_q);
		cmd.sel     = u.ra;
		cmd.ecnt    = ecnt_q;
		cmd.inf     = acc_inf_q;
		if (state_q == ST_FETCH) begin
			cmd.rd = u.op == OP_CONST || u.op == OP_RED || u.op == OP_ADD ||
				u.op == OP_SUB || u.op == OP_MUL || u.op == OP_CMP || u.op == OP_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			upc_q     <= '0;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			dbl_q     <= 1'b0;
			acc_inf_q <= 1'b1;
			q_inf_q   <= 1'b0;
			ecnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mag_q     <= start_mag;
						neg_q     <= start_neg;
						dbl_q     <= 1'b0;
						acc_inf_q <= 1'b1;
						q_inf_q   <= 1'b0;
						state_q   <= ST_FETCH;
						// Degenerate inputs skip straight to the result.
						if (stat.p_small || start_mag == '0 || point_infinity) begin
							upc_q <= UPC_FIN;
						end else begin
							upc_q <= '0;
						end
					end
				end
				ST_FETCH: begin
					unique case (u.op)
						OP_JMP:     upc_q <= cond_ok ? u.tgt : upc_q + 1'b1;
						OP_MODEADD: begin
							dbl_q <= 1'b0;
							upc_q <= upc_q + 1'b1;
						end
						OP_MODEDBL: begin
							dbl_q <= 1'b1;
							upc_q <= upc_q + 1'b1;
						end
						OP_SHIFT: begin
							mag_q <= mag_q >> 1;
							upc_q <= upc_q + 1'b1;
						end
						OP_EINIT: begin
							ecnt_q <= '0;
							upc_q  <= upc_q + 1'b1;
						end
						OP_EJMP: begin
							if (ecnt_q != ELAST) begin
								ecnt_q <= ecnt_q + 1'b1;
								upc_q  <= u.tgt;
							end else begin
								upc_q <= upc_q + 1'b1;
							end
						end
						OP_RET: begin
							if (!dbl_q) begin
								acc_inf_q <= 1'b0;
							end
							upc_q <= dbl_q ? UPC_LOOP : UPC_AFTERADD;
						end
						OP_RETINF: begin
							if (dbl_q) begin
								q_inf_q <= 1'b1;
							end else begin
								acc_inf_q <= 1'b1;
							end
							upc_q <= dbl_q ? UPC_LOOP : UPC_AFTERADD;
						end
						OP_RETN: upc_q <= dbl_q ? UPC_LOOP : UPC_AFTERADD;
						default: state_q <= ST_EXEC;
					endcase
				end
				ST_EXEC: begin
					if (u.op == OP_MUL || u.op == OP_RED) begin
						state_q <= ST_MULW;
					end else if (u.op == OP_FIN) begin
						state_q <= ST_IDLE;
					end else begin
						upc_q   <= upc_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_MULW: begin
					if (stat.mul_done) begin
						upc_q   <= upc_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
endmodule

>>> hw/rtl/ec_scalar_multiply.sv
// Top level of the affine elliptic-curve scalar multiplier.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------------------
//  command  | start in, busy out            | scalar, px, py, point_infinity
//  result   | done strobe out, one cycle    | rx, ry, result_infinity
//  config   | cfg_valid in, cfg_ready out   | cfg_index, cfg_data
//
// One transaction runs to completion before the next is taken; busy stays high
// meanwhile. Each field multiply runs in the shared bit-serial multiplier, and
// each point operation does up to 2*FIELD_BITS + 4 of them, most for the Fermat
// inversion.
// Reset clears the controller and loads the configuration defaults.
// The result strobe cannot be stalled; config is always ready.
module ec_scalar_multiply #(
	parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [SCALAR_BITS-1:0]         scalar,
	input  logic [FIELD_BITS-1:0]          px,
	input  logic [FIELD_BITS-1:0]          py,
	input  logic                           point_infinity,
	output logic                           done,
	output logic [FIELD_BITS-1:0]          rx,
	output logic [FIELD_BITS-1:0]          ry,
	output logic                           result_infinity,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_BITS-1:0]          cfg_data
);
	import ecsm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ecsm_ctrl #(
		.FIELD_BITS (FIELD_BITS),
		.SCALAR_BITS(SCALAR_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.scalar        (scalar),
		.point_infinity(point_infinity),
		.stat          (stat),
		.cmd           (cmd),
		.busy          (busy)
	);

	ecsm_datapath #(
		.FIELD_BITS(FIELD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.px             (px),
		.py             (py),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.rx             (rx),
		.ry             (ry),
		.result_infinity(result_infinity)
	);
endmodule

>>> hw/rtl/ecsm_checker.sv
// Port-level checker for the scalar multiplier, bound to the top level.
module ecsm_checker #(
	parameter int FIELD_BITS = 31
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [FIELD_BITS-1:0] rx,
	input logic [FIELD_BITS-1:0] ry,
	input logic                  result_infinity
);
	// An accepted transaction keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// The result strobe ends the transaction.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_infinity |-> rx == '0 && ry == '0)
		else $error("infinity result with nonzero coordinates");

	// A result only follows a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in flight");
endmodule

bind ec_scalar_multiply ecsm_checker #(.FIELD_BITS(FIELD_BITS)) u_ecsm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.rx             (rx),
	.ry             (ry),
	.result_infinity(result_infinity)
);
